// ===== rtl/kptl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kptl_pkg
// Shared types and constants of the kerning pair table lookup block.
// ----------------------------------------------------------------------------
package kptl_pkg;

	// Input kinds as carried on tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_GLYPH = 1'b1;

	// Configuration register indexes
	localparam logic REG_TABLE_LENGTH = 1'b0;
	localparam logic REG_SCALE        = 1'b1;

	localparam logic [23:0] SCALE_RESET = 24'h01_0000;

	// Table layout, in bytes
	localparam int HDR_BYTES        = 4;
	localparam int SUBHDR_BYTES     = 6;
	localparam int SEARCH_HDR_BYTES = 8;
	localparam int PAIR_BYTES       = 6;

	localparam int TADDR_W = 34;
	localparam int ADJ_W   = 48;
	localparam int PROD_W  = 41;

	typedef logic [TADDR_W-1:0] taddr_t;

	typedef enum logic {
		JOB_WRITE,
		JOB_GLYPH
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        has_pair;
		logic [15:0] g1;
		logic [15:0] g2;
		logic        is_final;
	} job_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_START,
		S_RD0,
		S_RD1,
		S_RD2,
		S_NTAB,
		S_WALK,
		S_SUBLEN,
		S_COV,
		S_NPAIRS,
		S_PROBE,
		S_KEYHI,
		S_KEYLO,
		S_VAL,
		S_ACC,
		S_EMIT_PAIR,
		S_EMIT_FINAL
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/kptl_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kptl_front
// Accepts input beats, keeps the held glyph and turns each beat into a job.
// ----------------------------------------------------------------------------
module kptl_front
	import kptl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic        s_axis_tuser,
	input  wire logic        s_axis_tlast,
	input  wire logic        q_full,
	output logic             q_push,
	output job_t             q_job
);

	logic [15:0] held_glyph_q;
	logic        held_valid_q;
	logic        accept;
	logic [15:0] glyph;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = accept;
	assign glyph         = s_axis_tdata[39:24];

	always_comb begin
		q_job.kind     = (s_axis_tuser == CMD_WRITE) ? JOB_WRITE : JOB_GLYPH;
		q_job.addr     = s_axis_tdata[15:0];
		q_job.data     = s_axis_tdata[23:16];
		q_job.has_pair = held_valid_q;
		q_job.g1       = held_glyph_q;
		q_job.g2       = glyph;
		q_job.is_final = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_glyph_q <= '0;
			held_valid_q <= 1'b0;
		end else if (accept && s_axis_tuser == CMD_GLYPH) begin
			if (s_axis_tlast) begin
				held_glyph_q <= '0;
				held_valid_q <= 1'b0;
			end else begin
				held_glyph_q <= glyph;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kptl_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kptl_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module kptl_fifo
	import kptl_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output job_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kptl_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kptl_back
// Table memory and the sequencer that walks subtables and searches pairs.
// ----------------------------------------------------------------------------
module kptl_back
	import kptl_pkg::*;
#(
	parameter int TABLE_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	input  job_t             job,
	output logic             job_pop,
	input  wire logic [16:0] table_length,
	input  wire logic [23:0] scale_q16,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,
	output logic             m_axis_tlast
);

	localparam int AW = $clog2(TABLE_BYTES);
	localparam int LW = $clog2(TABLE_BYTES + 1);

	logic [7:0] mem [TABLE_BYTES];
	logic [7:0] rdata_q;

	state_t state_q, state_d, ret_q;
	job_t   cur_q;

	taddr_t             addr_q, p_q, rec_q, rd_addr;
	logic               oob_q, rd_oob, mem_we, ld_ok, short_tab;
	logic [15:0]        word_q, ntab_q, t_q, sublen_q, mid_q, keyhi_q, mid_c;
	logic signed [17:0] lo_q, hi_q, lohi_sum;
	logic [18:0]        mid_x6;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ADJ_W-1:0]  acc_q, acc_sat;
	logic signed [ADJ_W:0]    acc_sum;
	logic [LW-1:0]      vlen;
	logic [AW-1:0]      rd_idx, wr_idx;
	logic [7:0]         byte_rd;
	logic [31:0]        key, probe_key;
	taddr_t             p_next;

	logic               out_valid_q, out_last_q;
	logic [ADJ_W-1:0]   out_adj_q;
	logic [15:0]        out_glyph_q;

	// Effective table length, never beyond the store
	always_comb begin
		if ({4'b0, table_length} > 21'(TABLE_BYTES)) begin
			vlen = LW'(TABLE_BYTES);
		end else begin
			vlen = LW'(table_length);
		end
	end

	assign short_tab = (vlen < LW'(HDR_BYTES));
	assign rd_addr   = (state_q == S_RD1) ? addr_q + 1'b1 : addr_q;
	assign rd_oob    = (rd_addr >= TADDR_W'(vlen));
	assign rd_idx    = rd_addr[AW-1:0];
	assign byte_rd   = oob_q ? 8'h00 : rdata_q;

	generate
		if (AW <= 16) begin : g_wr_narrow
			assign wr_idx = cur_q.addr[AW-1:0];
		end else begin : g_wr_wide
			assign wr_idx = {{(AW-16){1'b0}}, cur_q.addr};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= cur_q.data;
		end
		rdata_q <= mem[rd_idx];
		oob_q   <= rd_oob;
	end

	assign key       = {cur_q.g1, cur_q.g2};
	assign probe_key = {keyhi_q, word_q};
	assign lohi_sum  = lo_q + hi_q;
	assign mid_c     = lohi_sum[16:1];
	assign mid_x6    = {1'b0, mid_c, 2'b00} + {2'b00, mid_c, 1'b0};
	assign p_next    = p_q + TADDR_W'(sublen_q);

	// Saturating accumulate: overflow shows as the two top bits differing
	assign acc_sum = {acc_q[ADJ_W-1], acc_q} + (ADJ_W+1)'(prod_s1);
	always_comb begin
		if (acc_sum[ADJ_W] != acc_sum[ADJ_W-1]) begin
			acc_sat = acc_sum[ADJ_W] ? {1'b1, {(ADJ_W-1){1'b0}}} : {1'b0, {(ADJ_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ADJ_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (job_valid) state_d = S_START;
			end
			S_START: begin
				if (cur_q.kind == JOB_WRITE) state_d = S_IDLE;
				else if (cur_q.has_pair) state_d = short_tab ? S_EMIT_PAIR : S_RD0;
				else if (cur_q.is_final) state_d = S_EMIT_FINAL;
				else state_d = S_IDLE;
			end
			S_RD0:    state_d = S_RD1;
			S_RD1:    state_d = S_RD2;
			S_RD2:    state_d = ret_q;
			S_NTAB:   state_d = S_WALK;
			S_WALK:   state_d = (t_q == ntab_q) ? S_EMIT_PAIR : S_RD0;
			S_SUBLEN: state_d = S_RD0;
			S_COV:    state_d = (word_q[15:8] == 8'h00) ? S_RD0 : S_WALK;
			S_NPAIRS: state_d = S_PROBE;
			S_PROBE:  state_d = (lo_q <= hi_q) ? S_RD0 : S_WALK;
			S_KEYHI:  state_d = S_RD0;
			S_KEYLO:  state_d = (probe_key == key) ? S_RD0 : S_PROBE;
			S_VAL:    state_d = S_ACC;
			S_ACC:    state_d = S_WALK;
			S_EMIT_PAIR: begin
				if (ld_ok) state_d = cur_q.is_final ? S_EMIT_FINAL : S_IDLE;
			end
			S_EMIT_FINAL: begin
				if (ld_ok) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		ld_ok   = !out_valid_q || m_axis_tready;
		job_pop = (state_q == S_IDLE) && job_valid;
		mem_we  = (state_q == S_START) && (cur_q.kind == JOB_WRITE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_EMIT_PAIR || state_q == S_EMIT_FINAL) && ld_ok) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) cur_q <= job;
				acc_q <= '0;
			end
			S_START: begin
				addr_q <= TADDR_W'(2);
				ret_q  <= S_NTAB;
			end
			S_RD1: word_q[15:8] <= byte_rd;
			S_RD2: word_q[7:0]  <= byte_rd;
			S_NTAB: begin
				ntab_q <= word_q;
				t_q    <= '0;
				p_q    <= TADDR_W'(HDR_BYTES);
			end
			S_WALK: begin
				addr_q <= p_q + TADDR_W'(2);
				ret_q  <= S_SUBLEN;
			end
			S_SUBLEN: begin
				sublen_q <= word_q;
				addr_q   <= p_q + TADDR_W'(4);
				ret_q    <= S_COV;
			end
			S_COV: begin
				if (word_q[15:8] == 8'h00) begin
					addr_q <= p_q + TADDR_W'(SUBHDR_BYTES);
					ret_q  <= S_NPAIRS;
				end else begin
					p_q <= p_next;
					t_q <= t_q + 1'b1;
				end
			end
			S_NPAIRS: begin
				lo_q <= '0;
				hi_q <= $signed({2'b00, word_q}) - 18'sd1;
			end
			S_PROBE: begin
				if (lo_q <= hi_q) begin
					mid_q  <= mid_c;
					rec_q  <= p_q + TADDR_W'(SUBHDR_BYTES + SEARCH_HDR_BYTES)
						+ TADDR_W'(mid_x6);
					addr_q <= p_q + TADDR_W'(SUBHDR_BYTES + SEARCH_HDR_BYTES)
						+ TADDR_W'(mid_x6);
					ret_q  <= S_KEYHI;
				end else begin
					p_q <= p_next;
					t_q <= t_q + 1'b1;
				end
			end
			S_KEYHI: begin
				keyhi_q <= word_q;
				addr_q  <= rec_q + TADDR_W'(2);
				ret_q   <= S_KEYLO;
			end
			S_KEYLO: begin
				if (probe_key == key) begin
					addr_q <= rec_q + TADDR_W'(4);
					ret_q  <= S_VAL;
				end else if (probe_key < key) begin
					lo_q <= $signed({2'b00, mid_q}) + 18'sd1;
				end else begin
					hi_q <= $signed({2'b00, mid_q}) - 18'sd1;
				end
			end
			S_VAL: prod_s1 <= $signed(word_q) * $signed({1'b0, scale_q16});
			S_ACC: begin
				acc_q <= acc_sat;
				p_q   <= p_next;
				t_q   <= t_q + 1'b1;
			end
			S_EMIT_PAIR: begin
				if (ld_ok) begin
					out_adj_q   <= acc_q;
					out_glyph_q <= cur_q.g1;
					out_last_q  <= 1'b0;
				end
			end
			S_EMIT_FINAL: begin
				if (ld_ok) begin
					out_adj_q   <= '0;
					out_glyph_q <= cur_q.g2;
					out_last_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_glyph_q, out_adj_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/kern_pair_table_lookup_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kern_pair_table_lookup_top
// Kerning pair lookup over a byte image of a legacy kerning table.
// ----------------------------------------------------------------------------
// Load the table with write beats (tuser low), set table_length, then stream
// glyph beats (tuser high, tlast on the final glyph of a run). Each glyph beat
// after the first of a run yields the adjustment of the previous glyph; the
// final glyph also yields a zero result with tlast set. A write beat occupies
// the back end for its pickup and the start state, where the byte is written.
// A pair takes fixed work (job pickup, the subtable count read, the end of the
// walk and the result load) plus, for each subtable, its header reads; a
// format-0 subtable adds the read of its pair count and a closing step for a
// search that misses. Each binary-search probe reads the key words, and a hit
// adds the value read, the multiply and the accumulate. The zero result of a
// final glyph takes its own emit state, and a result held up at the output
// stalls the sequencer until it is taken. Every 16-bit read passes through the
// read states RD0, RD1 and RD2 on the single read port of the table memory. A
// four-entry job queue lets the input keep flowing while the sequencer is busy.
// ----------------------------------------------------------------------------
module kern_pair_table_lookup_top
	import kptl_pkg::*;
#(
	parameter int TABLE_BYTES = 65536,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // byte_address, byte_value, glyph_id
	input  wire logic        s_axis_tuser,  // cmd
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // adjust_q16, out_glyph
	output logic             m_axis_tlast
);

	logic [16:0] table_length_q;
	logic [23:0] scale_q;
	logic        q_push, q_full, q_pop, q_not_empty;
	job_t        q_job, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
			scale_q        <= SCALE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_TABLE_LENGTH) table_length_q <= cfg_data[16:0];
			else scale_q <= cfg_data;
		end
	end

	kptl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (q_job)
	);

	kptl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	kptl_back #(.TABLE_BYTES(TABLE_BYTES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_not_empty),
		.job           (q_head),
		.job_pop       (q_pop),
		.table_length  (table_length_q),
		.scale_q16     (scale_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/kptl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kptl_checker
// Port-level checks of the kerning pair lookup, bound to the top level.
// ----------------------------------------------------------------------------
module kptl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// The result for the final glyph of a run carries no adjustment.
	a_last_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[47:0] == 48'd0)
		else $error("final glyph result has a nonzero adjustment");

	// In the cycle after reset is sampled low, no result is shown.
	a_reset_quiet : assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	// A stalled result beat holds its contents.
	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result beat changed");

	// The input side always answers an offered beat with a known ready.
	a_in_ready_known : assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tready))
		else $error("input ready unknown");

endmodule

bind kern_pair_table_lookup_top kptl_checker u_kptl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
